[src/assert_macros.svh]
// Concurrent assertion helpers used by atl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ATL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define ATL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/atl_pkg.sv]
package atl_pkg;

	localparam int MAX_RECTS_DEF  = 256;
	localparam int COORD_BITS_DEF = 13;

	localparam int REQ_W  = 13;
	localparam int BPP_W  = 5;
	localparam int USED_W = 29;
	localparam int POS_W  = 12;
	localparam int SCAN_W = 17;
	localparam int PROD_W = 26;
	localparam int COST_W = 36;
	localparam int ADDR_W = 4;

	localparam logic [REQ_W-1:0] PAGE_W_RST = 13'd1024;
	localparam logic [REQ_W-1:0] PAGE_H_RST = 13'd1024;
	localparam logic [BPP_W-1:0] BPP_RST    = 5'd4;
	localparam logic [USED_W-1:0] USED_MAX  = {USED_W{1'b1}};

	localparam logic [1:0] ST_PLACED   = 2'd0;
	localparam logic [1:0] ST_NO_BYTES = 2'd1;
	localparam logic [1:0] ST_NO_FIT   = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] REG_PAGE_W = 2'd0;
	localparam logic [1:0] REG_PAGE_H = 2'd1;
	localparam logic [1:0] REG_BPP    = 2'd2;

	typedef struct packed {
		logic vld;
		logic hit;
	} atl_tok_t;

endpackage

[src/rect_atlas_allocator.sv]
// Rectangle atlas allocator. Stored rectangles live in a chain of MAX_RECTS
// cells; each overlap test travels the whole chain, one cell per cycle. A
// request runs one test per grid cell visited and one test per slide step (up
// to 5 + page size per axis); columns past a hit are skipped without a test.
// Results come one per request in request order through an output register.
module rect_atlas_allocator #(
	parameter int MAX_RECTS  = atl_pkg::MAX_RECTS_DEF,
	parameter int COORD_BITS = atl_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [atl_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [atl_pkg::REQ_W-1:0]           req_width,
	input  logic [atl_pkg::REQ_W-1:0]           req_height,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [atl_pkg::POS_W-1:0]           pos_left,
	output logic [atl_pkg::POS_W-1:0]           pos_top
);

	localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int SW = atl_pkg::SCAN_W;
	localparam int CB = COORD_BITS;
	localparam logic [SW-1:0] PAGE_MAX = SW'(1) << (COORD_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_CAP, S_CHECK, S_SCAN, S_ADV, S_SLIDE, S_WAIT, S_AXDONE,
		S_STORE, S_RESP
	} state_t;

	typedef enum logic [1:0] {
		PH_SCAN, PH_FIRST, PH_HALF, PH_LIN
	} phase_t;

	state_t state_q;
	phase_t ph_q;

	logic [atl_pkg::REQ_W-1:0]  page_w_q, page_h_q;
	logic [atl_pkg::BPP_W-1:0]  bpp_q;
	logic [CW-1:0]              cnt_q;
	logic [atl_pkg::USED_W-1:0] used_q;

	logic [atl_pkg::REQ_W-1:0]  w_q, h_q;
	logic [SW-1:0]              pw_q, ph_pg_q, cl_q, ct_q, hright_q;
	logic [atl_pkg::PROD_W-1:0] pwh_q, ppg_q;
	logic [atl_pkg::COST_W-1:0] cost_q, cap_q;
	logic [CB-1:0]              pos_q, oth_q, ext_q, oext_q, cand_q, left_q;
	logic                       vert_q;
	logic [2:0]                 k_q;
	logic [1:0]                 rstat_q;
	logic [CB-1:0]              rl_q, rt_q;

	logic                       qv_q;
	logic [CB-1:0]              ql_q, qt_q, qr_q, qb_q;
	logic                       we_q;

	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [atl_pkg::POS_W-1:0]  pos_left_q, pos_top_q;

	logic [SW-1:0]              pw_c, ph_c;
	logic [atl_pkg::COST_W-1:0] free_c;
	logic [CB-1:0]              step_c;
	logic [atl_pkg::COST_W-1:0] sum_c;
	logic                       wr_acc;
	logic                       qv_set, we_set;

	atl_pkg::atl_tok_t          tok [MAX_RECTS+1];
	logic [CB-1:0]              cql [MAX_RECTS+1];
	logic [CB-1:0]              cqt [MAX_RECTS+1];
	logic [CB-1:0]              cqr [MAX_RECTS+1];
	logic [CB-1:0]              cqb [MAX_RECTS+1];
	logic [CB-1:0]              chr [MAX_RECTS+1];

	assign tok[0].vld = qv_q;
	assign tok[0].hit = 1'b0;
	assign cql[0]     = ql_q;
	assign cqt[0]     = qt_q;
	assign cqr[0]     = qr_q;
	assign cqb[0]     = qb_q;
	assign chr[0]     = '0;

	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		atl_cell #(.COORD_BITS(CB), .IW(IW), .IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.we     (we_q),
			.widx   (cnt_q[IW-1:0]),
			.wl     (rl_q),
			.wt     (rt_q),
			.wr     (rl_q + CB'(w_q)),
			.wb     (rt_q + CB'(h_q)),
			.tok_i  (tok[i]),
			.ql_i   (cql[i]),
			.qt_i   (cqt[i]),
			.qr_i   (cqr[i]),
			.qb_i   (cqb[i]),
			.hr_i   (chr[i]),
			.tok_o  (tok[i+1]),
			.ql_o   (cql[i+1]),
			.qt_o   (cqt[i+1]),
			.qr_o   (cqr[i+1]),
			.qb_o   (cqb[i+1]),
			.hr_o   (chr[i+1])
		);
	end

	assign pready = 1'b1;
	assign wr_acc = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			atl_pkg::REG_PAGE_W: prdata = 32'(page_w_q);
			atl_pkg::REG_PAGE_H: prdata = 32'(page_h_q);
			atl_pkg::REG_BPP:    prdata = 32'(bpp_q);
			default:             prdata = '0;
		endcase
	end

	assign pw_c   = (SW'(page_w_q) < PAGE_MAX) ? SW'(page_w_q) : PAGE_MAX;
	assign ph_c   = (SW'(page_h_q) < PAGE_MAX) ? SW'(page_h_q) : PAGE_MAX;
	assign free_c = (cap_q > atl_pkg::COST_W'(used_q)) ?
	                (cap_q - atl_pkg::COST_W'(used_q)) : '0;
	assign step_c = ext_q >> k_q;
	assign sum_c  = cost_q + atl_pkg::COST_W'(used_q);

	assign qv_set = ((state_q == S_SCAN) && !(ct_q + SW'(h_q) > ph_pg_q) &&
	                 !(cl_q + SW'(w_q) > pw_q)) ||
	                ((state_q == S_SLIDE) &&
	                 ((ph_q == PH_HALF) ? (pos_q >= step_c) : (pos_q != '0)));
	assign we_set = (state_q == S_AXDONE) && vert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_w_q <= atl_pkg::PAGE_W_RST;
			page_h_q <= atl_pkg::PAGE_H_RST;
			bpp_q    <= atl_pkg::BPP_RST;
		end else if (wr_acc) begin
			case (paddr[3:2])
				atl_pkg::REG_PAGE_W: page_w_q <= pwdata[atl_pkg::REQ_W-1:0];
				atl_pkg::REG_PAGE_H: page_h_q <= pwdata[atl_pkg::REQ_W-1:0];
				atl_pkg::REG_BPP:    bpp_q    <= pwdata[atl_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_q <= 1'b0;
			we_q <= 1'b0;
		end else begin
			qv_q <= qv_set;
			we_q <= we_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_SCAN;
			cnt_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						w_q     <= req_width;
						h_q     <= req_height;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					pw_q    <= pw_c;
					ph_pg_q <= ph_c;
					pwh_q   <= w_q * h_q;
					ppg_q   <= atl_pkg::PROD_W'(pw_c * ph_c);
					state_q <= S_CAP;
				end
				S_CAP: begin
					cost_q  <= atl_pkg::COST_W'(pwh_q * bpp_q);
					cap_q   <= atl_pkg::COST_W'(ppg_q * bpp_q);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					rl_q <= '0;
					rt_q <= '0;
					if (cost_q > free_c) begin
						rstat_q <= atl_pkg::ST_NO_BYTES;
						state_q <= S_RESP;
					end else if (cnt_q >= CW'(MAX_RECTS)) begin
						rstat_q <= atl_pkg::ST_FULL;
						state_q <= S_RESP;
					end else if (w_q == '0 || h_q == '0) begin
						rstat_q <= atl_pkg::ST_NO_FIT;
						state_q <= S_RESP;
					end else begin
						cl_q    <= '0;
						ct_q    <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ct_q + SW'(h_q) > ph_pg_q) begin
						rstat_q <= atl_pkg::ST_NO_FIT;
						state_q <= S_RESP;
					end else if (cl_q + SW'(w_q) > pw_q) begin
						cl_q <= '0;
						ct_q <= ct_q + SW'(h_q);
					end else begin
						ql_q    <= CB'(cl_q);
						qt_q    <= CB'(ct_q);
						qr_q    <= CB'(cl_q + SW'(w_q));
						qb_q    <= CB'(ct_q + SW'(h_q));
						ph_q    <= PH_SCAN;
						state_q <= S_WAIT;
					end
				end
				S_ADV: begin
					if (cl_q < hright_q) begin
						cl_q <= cl_q + SW'(w_q);
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SLIDE: begin
					case (ph_q)
						PH_HALF: begin
							if (pos_q >= step_c) begin
								cand_q  <= pos_q - step_c;
								ql_q    <= vert_q ? oth_q : pos_q - step_c;
								qt_q    <= vert_q ? pos_q - step_c : oth_q;
								qr_q    <= vert_q ? oth_q + oext_q : pos_q - step_c + ext_q;
								qb_q    <= vert_q ? pos_q - step_c + ext_q : oth_q + oext_q;
								state_q <= S_WAIT;
							end else begin
								k_q <= k_q + 3'd1;
								if (k_q == 3'd4) begin
									ph_q <= PH_LIN;
								end
							end
						end
						default: begin
							if (pos_q == '0) begin
								state_q <= S_AXDONE;
							end else begin
								cand_q  <= pos_q - CB'(1);
								ql_q    <= vert_q ? oth_q : pos_q - CB'(1);
								qt_q    <= vert_q ? pos_q - CB'(1) : oth_q;
								qr_q    <= vert_q ? oth_q + oext_q : pos_q - CB'(1) + ext_q;
								qb_q    <= vert_q ? pos_q - CB'(1) + ext_q : oth_q + oext_q;
								state_q <= S_WAIT;
							end
						end
					endcase
				end
				S_WAIT: begin
					if (tok[MAX_RECTS].vld) begin
						case (ph_q)
							PH_SCAN: begin
								if (tok[MAX_RECTS].hit) begin
									hright_q <= SW'(chr[MAX_RECTS]);
									cl_q     <= cl_q + SW'(w_q);
									state_q  <= S_ADV;
								end else begin
									pos_q   <= CB'(cl_q);
									oth_q   <= CB'(ct_q);
									ext_q   <= CB'(w_q);
									oext_q  <= CB'(h_q);
									vert_q  <= 1'b0;
									ph_q    <= PH_FIRST;
									state_q <= S_SLIDE;
								end
							end
							PH_FIRST: begin
								if (tok[MAX_RECTS].hit) begin
									state_q <= S_AXDONE;
								end else begin
									k_q     <= 3'd1;
									ph_q    <= PH_HALF;
									state_q <= S_SLIDE;
								end
							end
							PH_HALF: begin
								if (!tok[MAX_RECTS].hit) begin
									pos_q <= cand_q;
								end
								k_q <= k_q + 3'd1;
								if (k_q == 3'd4) begin
									ph_q <= PH_LIN;
								end
								state_q <= S_SLIDE;
							end
							default: begin
								if (tok[MAX_RECTS].hit) begin
									state_q <= S_AXDONE;
								end else begin
									pos_q   <= cand_q;
									state_q <= S_SLIDE;
								end
							end
						endcase
					end
				end
				S_AXDONE: begin
					if (!vert_q) begin
						left_q  <= pos_q;
						pos_q   <= oth_q;
						oth_q   <= pos_q;
						ext_q   <= CB'(h_q);
						oext_q  <= CB'(w_q);
						vert_q  <= 1'b1;
						ph_q    <= PH_FIRST;
						state_q <= S_SLIDE;
					end else begin
						rl_q    <= left_q;
						rt_q    <= pos_q;
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					cnt_q   <= cnt_q + CW'(1);
					used_q  <= (sum_c > atl_pkg::COST_W'(atl_pkg::USED_MAX)) ?
					           atl_pkg::USED_MAX : sum_c[atl_pkg::USED_W-1:0];
					rstat_q <= atl_pkg::ST_PLACED;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= rstat_q;
						pos_left_q  <= atl_pkg::POS_W'(rl_q);
						pos_top_q   <= atl_pkg::POS_W'(rt_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pos_left  = pos_left_q;
	assign pos_top   = pos_top_q;

endmodule

[src/atl_cell.sv]
module atl_cell #(
	parameter int COORD_BITS = atl_pkg::COORD_BITS_DEF,
	parameter int IW = 8,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [IW-1:0]         widx,
	input  logic [COORD_BITS-1:0] wl,
	input  logic [COORD_BITS-1:0] wt,
	input  logic [COORD_BITS-1:0] wr,
	input  logic [COORD_BITS-1:0] wb,
	input  atl_pkg::atl_tok_t     tok_i,
	input  logic [COORD_BITS-1:0] ql_i,
	input  logic [COORD_BITS-1:0] qt_i,
	input  logic [COORD_BITS-1:0] qr_i,
	input  logic [COORD_BITS-1:0] qb_i,
	input  logic [COORD_BITS-1:0] hr_i,
	output atl_pkg::atl_tok_t     tok_o,
	output logic [COORD_BITS-1:0] ql_o,
	output logic [COORD_BITS-1:0] qt_o,
	output logic [COORD_BITS-1:0] qr_o,
	output logic [COORD_BITS-1:0] qb_o,
	output logic [COORD_BITS-1:0] hr_o
);

	logic                  vld_q;
	atl_pkg::atl_tok_t     tok_q;
	logic [COORD_BITS-1:0] rl_q, rt_q, rr_q, rb_q;
	logic [COORD_BITS-1:0] ql_q, qt_q, qr_q, qb_q, hr_q;
	logic [COORD_BITS-1:0] il, ir, it, ib;
	logic                  ovl, wsel;

	assign wsel = we && (widx == IW'(IDX));
	assign il   = (ql_i > rl_q) ? ql_i : rl_q;
	assign ir   = (qr_i < rr_q) ? qr_i : rr_q;
	assign it   = (qt_i > rt_q) ? qt_i : rt_q;
	assign ib   = (qb_i < rb_q) ? qb_i : rb_q;
	assign ovl  = vld_q && (il < ir) && (it < ib);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_q <= '0;
		end else begin
			if (wsel) begin
				vld_q <= 1'b1;
			end
			tok_q.vld <= tok_i.vld;
			tok_q.hit <= tok_i.hit | (tok_i.vld & ovl);
		end
	end

	always_ff @(posedge clk) begin
		if (wsel) begin
			rl_q <= wl;
			rt_q <= wt;
			rr_q <= wr;
			rb_q <= wb;
		end
		ql_q <= ql_i;
		qt_q <= qt_i;
		qr_q <= qr_i;
		qb_q <= qb_i;
		hr_q <= tok_i.hit ? hr_i : rr_q;
	end

	assign tok_o = tok_q;
	assign ql_o  = ql_q;
	assign qt_o  = qt_q;
	assign qr_o  = qr_q;
	assign qb_o  = qb_q;
	assign hr_o  = hr_q;

endmodule

[src/atl_checker.sv]
`include "assert_macros.svh"

module atl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pready,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 status,
	input logic [atl_pkg::POS_W-1:0]  pos_left,
	input logic [atl_pkg::POS_W-1:0]  pos_top
);

	`ATL_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
	`ATL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status), "result changed while stalled")
	`ATL_ASSERT(a_refused_pos, out_valid && status != atl_pkg::ST_PLACED |-> pos_left == '0 && pos_top == '0, "refused transaction carries a position")
	`ATL_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted a second transaction while busy")

endmodule

bind rect_atlas_allocator atl_checker u_atl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.pos_left  (pos_left),
	.pos_top   (pos_top)
);
